// ----- rtl/array_priority_queue_defines.svh -----
// Assertion macros used by the queue RTL.
`ifndef ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define ARRAY_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define APQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset.
`define APQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/apq_pkg.sv -----
package apq_pkg;

	localparam int PRI_W    = 16;
	localparam int PAY_W    = 32;
	localparam int STATUS_W = 2;

	// Operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// One stored slot
	typedef struct packed {
		logic [PRI_W-1:0] pri;
		logic [PAY_W-1:0] pay;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic                load_req;
		logic                ins_write;
		logic                scan_start;
		logic                scan_step;
		logic                shift_step;
		logic                set_status;
		logic [STATUS_W-1:0] status_code;
		logic                finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic op_remove;
		logic full;
		logic empty;
		logic scan_last;
		logic shift_done;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/apq_req_if.sv -----
interface apq_req_if;
	import apq_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    op;
	logic [PRI_W-1:0]        priority_req;
	logic signed [PAY_W-1:0] payload;

	modport source (output valid, output op, output priority_req, output payload,
		input ready);
	modport sink (input valid, input op, input priority_req, input payload,
		output ready);

endinterface

// ----- rtl/apq_rsp_if.sv -----
interface apq_rsp_if;
	import apq_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic [PRI_W-1:0]        out_priority;
	logic signed [PAY_W-1:0] out_payload;

	modport source (output valid, output status, output out_priority, output out_payload,
		input ready);
	modport sink (input valid, input status, input out_priority, input out_payload,
		output ready);

endinterface

// ----- rtl/apq_ctrl.sv -----
module apq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  apq_pkg::sts_t sts,
	output apq_pkg::cmd_t cmd
);
	import apq_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// Decode state into datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.set_status = 1'b1;
				if (!sts.op_remove) begin
					if (sts.full) begin
						cmd.status_code = ST_FULL;
					end else begin
						cmd.status_code = ST_OK;
						cmd.ins_write   = 1'b1;
					end
					state_d = S_RESULT;
				end else if (sts.empty) begin
					cmd.status_code = ST_EMPTY;
					state_d         = S_RESULT;
				end else begin
					cmd.status_code = ST_OK;
					cmd.scan_start  = 1'b1;
					state_d         = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (sts.shift_done) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/apq_dp.sv -----
module apq_dp #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  apq_pkg::cmd_t                    cmd,
	output apq_pkg::sts_t                    sts,
	input  logic                             in_op,
	input  logic [apq_pkg::PRI_W-1:0]        in_priority,
	input  logic signed [apq_pkg::PAY_W-1:0] in_payload,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [apq_pkg::STATUS_W-1:0]     out_status,
	output logic [apq_pkg::PRI_W-1:0]        out_priority,
	output logic signed [apq_pkg::PAY_W-1:0] out_payload
);
	import apq_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = IDX_W + 2;

	// Slot position head + offset, wrapped into the ring
	function automatic logic [IDX_W-1:0] wrap_pos(input logic [IDX_W-1:0] base,
		input logic [CNT_W-1:0] offs);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(offs);
		if (sum >= SUM_W'(QUEUE_DEPTH)) begin
			sum = sum - SUM_W'(QUEUE_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	entry_t mem [QUEUE_DEPTH];
	entry_t rd_data_q;

	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_k_q;
	logic [IDX_W-1:0] shift_k_q;
	logic             wr_pend_q;
	logic [IDX_W-1:0] wr_k_q;
	logic             rsp_valid_q;

	logic                op_q;
	logic [PRI_W-1:0]    pri_q;
	logic [PAY_W-1:0]    pay_q;
	logic [PRI_W-1:0]    best_pri_q;
	logic [PAY_W-1:0]    best_pay_q;
	logic [STATUS_W-1:0] status_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [PRI_W-1:0]    rsp_pri_q;
	logic [PAY_W-1:0]    rsp_pay_q;

	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic             wr_en;
	logic             take_best;
	logic             remove_ok;

	// Read one slot a cycle: head on start, next slot while scanning, source while shifting
	always_comb begin
		priority if (cmd.scan_start) begin
			rd_addr = head_q;
		end else if (cmd.shift_step) begin
			rd_addr = wrap_pos(head_q, CNT_W'(shift_k_q - 1'b1));
		end else begin
			rd_addr = wrap_pos(head_q, CNT_W'(scan_k_q + 1'b1));
		end
	end

	// Write the new tail on insert, or the pending shifted entry
	always_comb begin
		wr_en   = cmd.ins_write || wr_pend_q;
		wr_addr = wrap_pos(head_q, CNT_W'(wr_k_q));
		wr_data = rd_data_q;
		if (cmd.ins_write) begin
			wr_addr = wrap_pos(head_q, count_q);
			wr_data = '{pri: pri_q, pay: pay_q};
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Keep the first entry, then only a strictly higher priority
	assign take_best = (scan_k_q == '0) || (rd_data_q.pri > best_pri_q);
	assign remove_ok = (op_q == OP_REMOVE) && (status_q == ST_OK);

	// Control counters and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			scan_k_q    <= '0;
			shift_k_q   <= '0;
			wr_pend_q   <= 1'b0;
			wr_k_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				scan_k_q  <= '0;
				wr_pend_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				scan_k_q <= scan_k_q + 1'b1;
				if (take_best) begin
					shift_k_q <= scan_k_q[IDX_W-1:0];
				end
			end
			if (cmd.shift_step) begin
				if (shift_k_q != '0) begin
					shift_k_q <= shift_k_q - 1'b1;
					wr_k_q    <= shift_k_q;
					wr_pend_q <= 1'b1;
				end else begin
					wr_pend_q <= 1'b0;
				end
			end
			if (cmd.finish) begin
				if (op_q == OP_INSERT && status_q == ST_OK) begin
					count_q <= count_q + 1'b1;
				end else if (remove_ok) begin
					count_q <= count_q - 1'b1;
					head_q  <= wrap_pos(head_q, CNT_W'(1));
				end
			end
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (out_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request, best candidate and result holding registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q  <= in_op;
			pri_q <= in_priority;
			pay_q <= in_payload;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status_code;
		end
		if (cmd.scan_step && take_best) begin
			best_pri_q <= rd_data_q.pri;
			best_pay_q <= rd_data_q.pay;
		end
		if (cmd.finish) begin
			rsp_status_q <= status_q;
			rsp_pri_q    <= remove_ok ? best_pri_q : '0;
			rsp_pay_q    <= remove_ok ? best_pay_q : '0;
		end
	end

	assign sts.op_remove  = (op_q == OP_REMOVE);
	assign sts.full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign sts.empty      = (count_q == '0);
	assign sts.scan_last  = (CNT_W'(scan_k_q + 1'b1) == count_q);
	assign sts.shift_done = (shift_k_q == '0);
	assign sts.out_free   = !rsp_valid_q || out_ready;

	assign out_valid    = rsp_valid_q;
	assign out_status   = rsp_status_q;
	assign out_priority = rsp_pri_q;
	assign out_payload  = rsp_pay_q;

endmodule

// ----- rtl/array_priority_queue.sv -----
// Bounded priority queue of QUEUE_DEPTH entries held in a ring memory in arrival
// order. An insert (op 0) stores priority_req and payload at the tail, or answers
// status 1 when full; a remove (op 1) answers status 2 when empty, otherwise
// returns the oldest entry of highest priority and moves the older entries up to
// close the gap. Exactly one result per request; data fields are zero except on a
// successful remove. One request is worked at a time. A remove goes through the
// single read port of the slot memory, which visits each stored entry once to scan
// and each entry ahead of the chosen one once to shift. A new request is taken
// while the previous result is still held.
`include "array_priority_queue_defines.svh"

module array_priority_queue #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	apq_req_if.sink   req,
	apq_rsp_if.source rsp
);
	import apq_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	apq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	apq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_op        (req.op),
		.in_priority  (req.priority_req),
		.in_payload   (req.payload),
		.out_ready    (rsp.ready),
		.out_valid    (rsp.valid),
		.out_status   (rsp.status),
		.out_priority (rsp.out_priority),
		.out_payload  (rsp.out_payload)
	);

	assign req.ready = in_ready;

	// Checks on the controller and datapath
	`APQ_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "second request taken while busy")
	`APQ_ASSERT_NOW(a_finish_free, cmd.finish, sts.out_free, "result loaded over a held result")
	`APQ_ASSERT_NOW(a_no_write_full, cmd.ins_write, !sts.full, "insert written into a full queue")
	`APQ_ASSERT_NEXT(a_finish_valid, cmd.finish, rsp.valid, "finished result not presented")

endmodule

// ----- sim/apq_result_checker.sv -----
`timescale 1ns / 1ps

module apq_result_checker #(
	parameter int DEPTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	apq_req_if        req,
	apq_rsp_if        rsp,
	output int        fail_count,
	output int        pending,
	output int        n_stored,
	output int        n_full,
	output int        n_served,
	output int        n_empty
);
	import apq_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PRI_W-1:0]    pri;
		logic [PAY_W-1:0]    pay;
	} answer_t;

	// Own copy of the ring: slots, oldest position and fill level
	logic [PRI_W-1:0] held_pri [DEPTH];
	logic [PAY_W-1:0] held_pay [DEPTH];
	int               oldest;
	int               fill;
	answer_t          due_answers [$];

	// Work out the answer to one request and update the ring copy
	function automatic answer_t serve_request(logic op, logic [PRI_W-1:0] pri,
			logic [PAY_W-1:0] pay);
		answer_t          ans;
		int               best;
		int               k;
		int               slot;
		logic [PRI_W-1:0] top_pri;
		ans.status = ST_OK;
		ans.pri    = '0;
		ans.pay    = '0;
		if (op == OP_INSERT) begin
			if (fill >= DEPTH) begin
				ans.status = ST_FULL;
			end else begin
				slot           = (oldest + fill) % DEPTH;
				held_pri[slot] = pri;
				held_pay[slot] = pay;
				fill++;
			end
		end else if (fill == 0) begin
			ans.status = ST_EMPTY;
		end else begin
			// strictly greater keeps the oldest among equal priorities
			best    = 0;
			top_pri = held_pri[oldest];
			for (k = 1; k < fill; k++) begin
				if (held_pri[(oldest + k) % DEPTH] > top_pri) begin
					top_pri = held_pri[(oldest + k) % DEPTH];
					best    = k;
				end
			end
			slot    = (oldest + best) % DEPTH;
			ans.pri = held_pri[slot];
			ans.pay = held_pay[slot];
			// close the gap by moving older entries up one slot
			for (k = best; k > 0; k--) begin
				held_pri[(oldest + k) % DEPTH] = held_pri[(oldest + k - 1) % DEPTH];
				held_pay[(oldest + k) % DEPTH] = held_pay[(oldest + k - 1) % DEPTH];
			end
			held_pri[oldest] = '0;
			held_pay[oldest] = '0;
			oldest           = (oldest + 1) % DEPTH;
			fill--;
		end
		return ans;
	endfunction

	// Predict on each request transfer, compare on each result transfer
	always @(posedge clk or negedge arst_n) begin
		answer_t due;
		answer_t got;
		int      errs;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				held_pri[i] = '0;
				held_pay[i] = '0;
			end
			oldest = 0;
			fill   = 0;
			due_answers.delete();
			fail_count <= 0;
			pending    <= 0;
			n_stored   <= 0;
			n_full     <= 0;
			n_served   <= 0;
			n_empty    <= 0;
		end else begin
			errs = 0;
			if (req.valid && req.ready) begin
				due = serve_request(req.op, req.priority_req, req.payload);
				due_answers.push_back(due);
				case (due.status)
					ST_FULL:  n_full   <= n_full + 1;
					ST_EMPTY: n_empty  <= n_empty + 1;
					default: begin
						if (req.op == OP_INSERT)
							n_stored <= n_stored + 1;
						else
							n_served <= n_served + 1;
					end
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				got.status = rsp.status;
				got.pri    = rsp.out_priority;
				got.pay    = rsp.out_payload;
				if (due_answers.size() == 0) begin
					$display("%0t: unexpected result status=%0d priority=%0d payload=%0h",
						$time, got.status, got.pri, got.pay);
					errs++;
				end else begin
					due = due_answers.pop_front();
					if (got.status !== due.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, due.status, got.status);
						errs++;
					end
					if (got.pri !== due.pri) begin
						$display("%0t: out_priority expected %0d, got %0d",
							$time, due.pri, got.pri);
						errs++;
					end
					if (got.pay !== due.pay) begin
						$display("%0t: out_payload expected %08h, got %08h",
							$time, due.pay, got.pay);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending    <= due_answers.size();
		end
	end

endmodule

// ----- sim/tb_array_priority_queue.sv -----
`timescale 1ns / 1ps

module tb_array_priority_queue;
	import apq_pkg::*;

	localparam int DEPTH       = 8;
	localparam int PHASES      = 13;
	localparam int PHASE_ITEMS = 149;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	bit   quiet;
	int   cycles;
	int   fail_count;
	int   pending;
	int   n_stored;
	int   n_full;
	int   n_served;
	int   n_empty;

	apq_req_if req_ch();
	apq_rsp_if rsp_ch();

	array_priority_queue #(
		.QUEUE_DEPTH(DEPTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	apq_result_checker #(
		.DEPTH(DEPTH)
	) u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending),
		.n_stored   (n_stored),
		.n_full     (n_full),
		.n_served   (n_served),
		.n_empty    (n_empty)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one; none in quiet stretches
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Priority drawn according to the phase's mix
	function automatic logic [PRI_W-1:0] pick_priority(int mix);
		case (mix)
			0:       return PRI_W'($urandom);
			1:       return PRI_W'($urandom_range(0, 3));
			2: begin
				case ($urandom_range(0, 3))
					0:       return '0;
					1:       return PRI_W'(1);
					2:       return '1;
					default: return {{(PRI_W-1){1'b1}}, 1'b0};
				endcase
			end
			default: return PRI_W'($urandom_range(1, 20));
		endcase
	endfunction

	// Offer one request after a random gap and hold it until the transfer
	task automatic send_request(logic op, logic [PRI_W-1:0] pri, logic [PAY_W-1:0] pay);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.op           <= op;
		req_ch.priority_req <= pri;
		req_ch.payload      <= pay;
		@(negedge clk);
		while (!req_ch.ready) @(negedge clk);
		@(posedge clk);
	endtask

	// Drop valid and hold off until every answer has come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Result side: random stalls
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				hold_left = pick_gap();
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int ins_pct;
		int mix;
		quiet = 1'b0;
		arst_n = 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.op           <= OP_INSERT;
		req_ch.priority_req <= '0;
		req_ch.payload      <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// remove from an empty queue
		send_request(OP_REMOVE, '0, '1);
		// fill with extremes, priority zero and a three-way tie
		send_request(OP_INSERT, 16'd500, 32'h0000_0001);
		send_request(OP_INSERT, '1, 32'h7fff_ffff);
		send_request(OP_INSERT, 16'd1, 32'h8000_0000);
		send_request(OP_INSERT, '0, 32'hffff_ffff);
		send_request(OP_INSERT, 16'd500, 32'h0000_0002);
		send_request(OP_INSERT, '1, 32'h0000_0000);
		send_request(OP_INSERT, 16'd500, 32'h0000_0003);
		send_request(OP_INSERT, 16'd2, 32'h5555_aaaa);
		// insert into a full queue
		send_request(OP_INSERT, 16'd9, 32'h1234_5678);
		// empty it again, then once more past empty
		repeat (DEPTH + 1) send_request(OP_REMOVE, 16'hffff, 32'hdead_beef);
		drain();

		// random phases, each with its own insert bias and priority mix
		for (int ph = 0; ph < PHASES; ph++) begin
			quiet = (ph % 4 == 1);
			case ($urandom_range(0, 4))
				0:       ins_pct = 85;
				1:       ins_pct = 65;
				2:       ins_pct = 50;
				3:       ins_pct = 35;
				default: ins_pct = 15;
			endcase
			mix = $urandom_range(0, 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < ins_pct)
					send_request(OP_INSERT, pick_priority(mix), PAY_W'($urandom));
				else
					send_request(OP_REMOVE, PRI_W'($urandom), PAY_W'($urandom));
			end
			drain();
		end

		quiet = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Requests: %0d stored, %0d refused as full, %0d served, %0d refused as empty",
			n_stored, n_full, n_served, n_empty);
		$display("Directed extremes and ties, then %0d random phases with mixed stalls",
			PHASES);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial cycles = 0;

endmodule
